// ----- hw/rtl/epoch_seconds_to_calendar_top_defines.svh -----
// Assertion macros for the epoch seconds to calendar block.
// Expect clk and rst_n in the scope of each use; no other dependencies.
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ECAL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ECAL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ecal_pkg.sv -----
// Constants, reciprocals and lookup functions for the epoch to calendar block.
// No dependencies; imported by epoch_seconds_to_calendar_top.
`default_nettype none

package ecal_pkg;

  localparam int unsigned IN_W   = 39;
  localparam int unsigned TDATA_IN_W  = 40;
  localparam int unsigned TDATA_OUT_W = 48;

  // Bias the day count by whole eras so every value below stays non-negative.
  localparam int unsigned ERA_BIAS = 17;
  localparam logic [39:0] SEC_OFFSET =
    40'((64'd719468 + 64'd17 * 64'd146097) * 64'd86400);

  localparam logic [9:0]  DAY_DIV_LO = 10'd675;      // 86400 / 128
  localparam logic [17:0] ERA_DAYS   = 18'd146097;
  localparam logic [17:0] DOE_LAST   = 18'd146096;
  localparam logic [17:0] CENT_DAYS  = 18'd36524;
  localparam logic [11:0] SEC_PER_HR = 12'd3600;
  localparam logic [11:0] SEC_PER_MN = 12'd60;
  localparam logic [17:0] DAYS_PER_YR = 18'd365;
  localparam logic [14:0] DAYS_400Y_YRS = 15'd400;
  localparam logic [14:0] YEAR_BASE  = 15'(ERA_BIAS * 400);
  localparam logic [14:0] YEAR_TOP   = 15'(ERA_BIAS * 400 + 9999);
  localparam logic [3:0]  MP_JAN     = 4'd10;        // March-based index of January

  // Reciprocals m = ceil(2^s / d); exact floor division for the operand widths used.
  localparam logic [17:0] DA_M    = 18'(((64'd1 << 27) + 64'd674) / 64'd675);
  localparam logic [26:0] DB_M    = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam logic [23:0] ERA_M   = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
  localparam logic [17:0] HR_M    = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MIN_M   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [18:0] D1460_M = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] D365_M  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [14:0] MP_M5   = 15'(5 * (((64'd1 << 19) + 64'd152) / 64'd153));
  localparam logic [14:0] MP_M2   = 15'(2 * (((64'd1 << 19) + 64'd152) / 64'd153));

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [13:0] year;
    logic        valid_res;
  } res_t;

  localparam int unsigned OUT_PAD = TDATA_OUT_W - $bits(res_t);

  // First day of year (March based) for each month index: (153 * mp + 2) / 5.
  function automatic logic [8:0] mp_base(input logic [3:0] mp);
    logic [8:0] base;
    unique case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/epoch_seconds_to_calendar_top.sv -----
// Signed Unix seconds to proleptic Gregorian date and time of day.
// Depends on ecal_pkg and epoch_seconds_to_calendar_top_defines.svh.
//
// The block takes one 39-bit signed count of seconds since 1970-01-01 00:00:00
// per item and returns one item with year, month, day, hour, minute and
// second. Days are the floor of seconds / 86400, so times before the epoch
// land on the right day with a non-negative time of day. Years outside 0 to
// 9999 give valid_res = 0 and year = 0; the other fields keep the computed
// values. Throughput is one item per clock while the output is not stalled; an
// item passes a 14-stage pipeline whose first stage loads at the accepting
// edge and whose last stage drives out_tvalid. Most divisions by a constant
// are a reciprocal multiply in one stage and the matching remainder a constant
// multiply-subtract in the next; century terms use compares. Each stage holds
// its own valid bit and loads whenever it is empty or moving on, so bubbles
// close up under output back-pressure and a stall drops nothing.
`default_nettype none
`include "epoch_seconds_to_calendar_top_defines.svh"

module epoch_seconds_to_calendar_top
  import ecal_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [TDATA_IN_W-1:0]  in_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [TDATA_OUT_W-1:0]      out_tdata   // [0] valid_res, [14:1] year,
                                                  // [18:15] month, [23:19] day_of_month,
                                                  // [28:24] hour, [34:29] minute,
                                                  // [40:35] second, [47:41] zero
);

  localparam int unsigned NSTG = 14;

  // Pipeline control: stage k loads when empty or when its item moves on.
  logic [NSTG:1]   v_r;
  logic [NSTG+1:1] rdy;
  logic [NSTG:1]   v_in;

  always_comb begin
    rdy[NSTG+1] = out_tready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_in      = {v_r[NSTG-1:1], in_tvalid};
  assign in_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // Stage registers.
  logic [39:0] t1_r,    t1_nxt;
  logic [7:0]  a2_r,    a2_nxt;
  logic [16:0] h2_r,    h2_nxt;
  logic [22:0] lo2_r,   lo2_nxt;
  logic [7:0]  a3_r,    a3_nxt;
  logic [25:0] x3_r,    x3_nxt;
  logic [6:0]  s3_r,    s3_nxt;
  logic [7:0]  a4_r,    a4_nxt;
  logic [25:0] x4_r,    x4_nxt;
  logic [6:0]  s4_r,    s4_nxt;
  logic [15:0] b4_r,    b4_nxt;
  logic [22:0] z5_r,    z5_nxt;
  logic [16:0] sod5_r,  sod5_nxt;
  logic [5:0]  era6_r,  era6_nxt;
  logic [22:0] z6_r,    z6_nxt;
  logic [4:0]  hr6_r,   hr6_nxt;
  logic [16:0] sod6_r,  sod6_nxt;
  logic [5:0]  era7_r,  era7_nxt;
  logic [17:0] doe7_r,  doe7_nxt;
  logic [4:0]  hr7_r,   hr7_nxt;
  logic [11:0] rest7_r, rest7_nxt;
  logic [5:0]  era8_r,  era8_nxt;
  logic [17:0] doe8_r,  doe8_nxt;
  logic [6:0]  a8_r,    a8_nxt;
  logic [2:0]  b8_r,    b8_nxt;
  logic        c8_r,    c8_nxt;
  logic [4:0]  hr8_r,   hr8_nxt;
  logic [11:0] rest8_r, rest8_nxt;
  logic [5:0]  mn8_r,   mn8_nxt;
  logic [5:0]  era9_r,  era9_nxt;
  logic [17:0] doe9_r,  doe9_nxt;
  logic [17:0] n9_r,    n9_nxt;
  tod_t        tod9_r,  tod9_nxt;
  logic [5:0]  era10_r, era10_nxt;
  logic [17:0] doe10_r, doe10_nxt;
  logic [8:0]  yoe10_r, yoe10_nxt;
  tod_t        tod10_r, tod10_nxt;
  logic [5:0]  era11_r, era11_nxt;
  logic [8:0]  yoe11_r, yoe11_nxt;
  logic [8:0]  doy11_r, doy11_nxt;
  tod_t        tod11_r, tod11_nxt;
  logic [5:0]  era12_r, era12_nxt;
  logic [8:0]  yoe12_r, yoe12_nxt;
  logic [8:0]  doy12_r, doy12_nxt;
  logic [3:0]  mp12_r,  mp12_nxt;
  tod_t        tod12_r, tod12_nxt;
  logic [14:0] ye13_r,  ye13_nxt;
  logic [3:0]  mo13_r,  mo13_nxt;
  logic [4:0]  dy13_r,  dy13_nxt;
  tod_t        tod13_r, tod13_nxt;
  res_t        out_r,   out_nxt;

  // Intermediate products and remainders.
  logic [34:0] prod_a;
  logic [16:0] rem_a;
  logic [52:0] prod_b;
  logic [25:0] rem_b;
  logic [46:0] prod_era;
  logic [34:0] prod_hr;
  logic [22:0] era_days;
  logic [16:0] hr_secs;
  logic [36:0] prod_1460;
  logic [24:0] prod_mn;
  logic [11:0] mn_secs;
  logic [36:0] prod_365;
  logic [1:0]  cent;
  logic [17:0] yr_days;
  logic [23:0] prod_mp;
  logic [8:0]  day_idx;
  logic        in_range;

  always_comb begin
    // Stage 1: sign-extend and bias by whole eras of days.
    t1_nxt = {in_tdata[IN_W-1], in_tdata[IN_W-1:0]} + SEC_OFFSET;

    // Stage 2: high digit of (t / 128) / 675.
    h2_nxt  = t1_r[39:23];
    prod_a  = 35'(t1_r[39:23]) * 35'(DA_M);
    a2_nxt  = prod_a[34:27];
    lo2_nxt = t1_r[22:0];

    // Stage 3: remainder of the high digit joins the low 16 bits.
    rem_a  = h2_r - 17'(a2_r) * 17'(DAY_DIV_LO);
    x3_nxt = {rem_a[9:0], lo2_r[22:7]};
    s3_nxt = lo2_r[6:0];
    a3_nxt = a2_r;

    // Stage 4: low digit of the day count.
    prod_b = 53'(x3_r) * 53'(DB_M);
    b4_nxt = prod_b[51:36];
    a4_nxt = a3_r;
    x4_nxt = x3_r;
    s4_nxt = s3_r;

    // Stage 5: biased day number and second of day.
    rem_b    = x4_r - 26'(b4_r) * 26'(DAY_DIV_LO);
    z5_nxt   = 23'({a4_r, b4_r});
    sod5_nxt = {rem_b[9:0], s4_r};

    // Stage 6: era and hour.
    prod_era = 47'(z5_r) * 47'(ERA_M);
    era6_nxt = prod_era[46:41];
    prod_hr  = 35'(sod5_r) * 35'(HR_M);
    hr6_nxt  = prod_hr[33:29];
    z6_nxt   = z5_r;
    sod6_nxt = sod5_r;

    // Stage 7: day of era and seconds within the hour.
    era_days  = z6_r - 23'(era6_r) * 23'(ERA_DAYS);
    doe7_nxt  = era_days[17:0];
    hr_secs   = sod6_r - 17'(hr6_r) * 17'(SEC_PER_HR);
    rest7_nxt = hr_secs[11:0];
    era7_nxt  = era6_r;
    hr7_nxt   = hr6_r;

    // Stage 8: leap-day corrections and minute.
    prod_1460 = 37'(doe7_r) * 37'(D1460_M);
    a8_nxt    = prod_1460[35:29];
    priority if (doe7_r >= 18'(4 * CENT_DAYS)) begin
      b8_nxt = 3'd4;
    end else if (doe7_r >= 18'(3 * CENT_DAYS)) begin
      b8_nxt = 3'd3;
    end else if (doe7_r >= 18'(2 * CENT_DAYS)) begin
      b8_nxt = 3'd2;
    end else if (doe7_r >= CENT_DAYS) begin
      b8_nxt = 3'd1;
    end else begin
      b8_nxt = 3'd0;
    end
    c8_nxt    = (doe7_r == DOE_LAST);
    prod_mn   = 25'(rest7_r) * 25'(MIN_M);
    mn8_nxt   = prod_mn[23:18];
    era8_nxt  = era7_r;
    doe8_nxt  = doe7_r;
    hr8_nxt   = hr7_r;
    rest8_nxt = rest7_r;

    // Stage 9: corrected day of era and second.
    n9_nxt          = doe8_r - 18'(a8_r) + 18'(b8_r) - 18'(c8_r);
    mn_secs         = rest8_r - 12'(mn8_r) * SEC_PER_MN;
    tod9_nxt.hour   = hr8_r;
    tod9_nxt.minute = mn8_r;
    tod9_nxt.second = mn_secs[5:0];
    era9_nxt        = era8_r;
    doe9_nxt        = doe8_r;

    // Stage 10: year of era.
    prod_365  = 37'(n9_r) * 37'(D365_M);
    yoe10_nxt = prod_365[35:27];
    era10_nxt = era9_r;
    doe10_nxt = doe9_r;
    tod10_nxt = tod9_r;

    // Stage 11: day of year, March based.
    priority if (yoe10_r >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe10_r >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe10_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    yr_days   = 18'(yoe10_r) * DAYS_PER_YR + 18'(yoe10_r[8:2]) - 18'(cent);
    doy11_nxt = 9'(doe10_r - yr_days);
    era11_nxt = era10_r;
    yoe11_nxt = yoe10_r;
    tod11_nxt = tod10_r;

    // Stage 12: March-based month index, (5 * doy + 2) / 153.
    prod_mp   = 24'(doy11_r) * 24'(MP_M5) + 24'(MP_M2);
    mp12_nxt  = prod_mp[22:19];
    era12_nxt = era11_r;
    yoe12_nxt = yoe11_r;
    doy12_nxt = doy11_r;
    tod12_nxt = tod11_r;

    // Stage 13: day, civil month and biased year.
    day_idx   = doy12_r - mp_base(mp12_r) + 9'd1;
    dy13_nxt  = day_idx[4:0];
    mo13_nxt  = (mp12_r < MP_JAN) ? (mp12_r + 4'd3) : (mp12_r - 4'd9);
    ye13_nxt  = 15'(era12_r) * DAYS_400Y_YRS + 15'(yoe12_r) + 15'(mp12_r >= MP_JAN);
    tod13_nxt = tod12_r;

    // Stage 14: remove the era bias and check the four-digit range.
    in_range             = (ye13_r >= YEAR_BASE) && (ye13_r <= YEAR_TOP);
    out_nxt.valid_res    = in_range;
    out_nxt.year         = in_range ? 14'(ye13_r - YEAR_BASE) : 14'd0;
    out_nxt.month        = mo13_r;
    out_nxt.day_of_month = dy13_r;
    out_nxt.hour         = tod13_r.hour;
    out_nxt.minute       = tod13_r.minute;
    out_nxt.second       = tod13_r.second;
  end

  // Payload: advance each stage with its valid bit, hold otherwise.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      t1_r <= t1_nxt;
    end
    if (rdy[2]) begin
      a2_r  <= a2_nxt;
      h2_r  <= h2_nxt;
      lo2_r <= lo2_nxt;
    end
    if (rdy[3]) begin
      a3_r <= a3_nxt;
      x3_r <= x3_nxt;
      s3_r <= s3_nxt;
    end
    if (rdy[4]) begin
      a4_r <= a4_nxt;
      x4_r <= x4_nxt;
      s4_r <= s4_nxt;
      b4_r <= b4_nxt;
    end
    if (rdy[5]) begin
      z5_r   <= z5_nxt;
      sod5_r <= sod5_nxt;
    end
    if (rdy[6]) begin
      era6_r <= era6_nxt;
      z6_r   <= z6_nxt;
      hr6_r  <= hr6_nxt;
      sod6_r <= sod6_nxt;
    end
    if (rdy[7]) begin
      era7_r  <= era7_nxt;
      doe7_r  <= doe7_nxt;
      hr7_r   <= hr7_nxt;
      rest7_r <= rest7_nxt;
    end
    if (rdy[8]) begin
      era8_r  <= era8_nxt;
      doe8_r  <= doe8_nxt;
      a8_r    <= a8_nxt;
      b8_r    <= b8_nxt;
      c8_r    <= c8_nxt;
      hr8_r   <= hr8_nxt;
      rest8_r <= rest8_nxt;
      mn8_r   <= mn8_nxt;
    end
    if (rdy[9]) begin
      era9_r <= era9_nxt;
      doe9_r <= doe9_nxt;
      n9_r   <= n9_nxt;
      tod9_r <= tod9_nxt;
    end
    if (rdy[10]) begin
      era10_r <= era10_nxt;
      doe10_r <= doe10_nxt;
      yoe10_r <= yoe10_nxt;
      tod10_r <= tod10_nxt;
    end
    if (rdy[11]) begin
      era11_r <= era11_nxt;
      yoe11_r <= yoe11_nxt;
      doy11_r <= doy11_nxt;
      tod11_r <= tod11_nxt;
    end
    if (rdy[12]) begin
      era12_r <= era12_nxt;
      yoe12_r <= yoe12_nxt;
      doy12_r <= doy12_nxt;
      mp12_r  <= mp12_nxt;
      tod12_r <= tod12_nxt;
    end
    if (rdy[13]) begin
      ye13_r  <= ye13_nxt;
      mo13_r  <= mo13_nxt;
      dy13_r  <= dy13_nxt;
      tod13_r <= tod13_nxt;
    end
    if (rdy[14]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_r};

  // A draining output leaves no stage blocked, so the input must be open.
  `ECAL_ASSERT_IMPLY(a_ready_chain, out_tready, in_tready, "input stalled while output drains")
  // Time-of-day, month and day-of-month fields stay in range on every delivered item.
  `ECAL_ASSERT_IMPLY(a_fields_range, out_tvalid,
    (out_r.month >= 4'd1) && (out_r.month <= 4'd12) && (out_r.day_of_month != 5'd0) &&
    (out_r.hour <= 5'd23) && (out_r.minute <= 6'd59) && (out_r.second <= 6'd59),
    "calendar field out of range")
  // An out-of-range year reports as zero.
  `ECAL_ASSERT_ALWAYS(a_year_zero, !out_tvalid || out_r.valid_res || (out_r.year == 14'd0),
    "year not cleared for invalid result")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for epoch_seconds_to_calendar_top: drives signed Unix timestamps
// and compares each returned date and time of day against a built-in calendar predictor.
// Depends on ecal_pkg (port widths, result layout) and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb;
  import ecal_pkg::*;

  localparam int unsigned RES_W      = $bits(res_t);
  localparam int unsigned CYCLE_CAP  = 200000;  // far above the length of a clean run
  localparam int unsigned RAND_ITEMS = 2000;
  localparam int unsigned DRAIN_CYC  = 40;      // pipeline is 14 deep; leave room for stalls

  // Expected result paired with the timestamp that caused it, for readable reports.
  typedef struct {
    logic [IN_W-1:0] epoch;
    res_t            date;
  } date_due_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [TDATA_IN_W-1:0]  in_tdata;    // [38:0] epoch_seconds, [39] zero
  logic                   out_tvalid;
  logic                   out_tready;
  logic [TDATA_OUT_W-1:0] out_tdata;   // [0] valid_res, [14:1] year, [18:15] month,
                                       // [23:19] day_of_month, [28:24] hour,
                                       // [34:29] minute, [40:35] second, [47:41] zero

  logic [IN_W-1:0] pending_epochs[$];   // timestamps not yet handed to the block
  date_due_t       expected_dates[$];   // dates owed by the block, oldest first

  int unsigned cyc = 0;
  int unsigned mismatches = 0;
  int unsigned dates_checked = 0;
  int unsigned out_of_range_seen = 0;
  int unsigned directed_cnt = 0;
  logic        quiet;                   // window with no idling on either side
  res_t        got;
  date_due_t   due;

  epoch_seconds_to_calendar_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  assign quiet = (cyc >= 1500) && (cyc < 2500);

  // Predict the calendar date of one timestamp. Floor the day so that times before
  // midnight of a negative day stay on that day, then walk eras, years and the
  // March-based month. Years outside 0..9999 clear valid_res and zero the year only.
  function automatic res_t civil_from_epoch(input logic [IN_W-1:0] raw);
    longint secs, days, sod, r0, era, doe, yoe, y, doy, mp, d, m;
    logic   ok;
    res_t   r;
    secs = $signed(raw);
    days = secs / 86400;
    sod  = secs % 86400;
    if (sod < 0) begin
      sod  = sod + 86400;
      days = days - 1;
    end
    r0  = days + 719468;
    era = (r0 >= 0 ? r0 : r0 - 146096) / 146097;
    doe = r0 - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y   = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? (mp + 3) : (mp - 9);
    if (m <= 2)
      y = y + 1;
    ok = (y >= 0) && (y <= 9999);
    r.valid_res    = ok;
    r.year         = ok ? 14'(y) : 14'd0;
    r.month        = 4'(m);
    r.day_of_month = 5'(d);
    r.hour         = 5'(sod / 3600);
    r.minute       = 6'((sod % 3600) / 60);
    r.second       = 6'(sod % 60);
    return r;
  endfunction

  task automatic check_field(input string fname, input longint want_v, input longint got_v,
                             input logic [IN_W-1:0] epoch);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch for epoch %0d: expected %0d, actual %0d",
               $time, fname, $signed(epoch), want_v, got_v);
    end
  endtask

  // Driver: advance to the next timestamp once the current one is taken, idling
  // now and then outside the quiet window. Keep tvalid up across back-to-back items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_epochs.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, pending_epochs.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: record a prediction for every accepted timestamp, stall the result
  // side at random, and check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 18);
      if (in_tvalid && in_tready)
        expected_dates.push_back('{in_tdata[IN_W-1:0], civil_from_epoch(in_tdata[IN_W-1:0])});
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (expected_dates.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing outstanding: expected none, actual %h",
                   $time, out_tdata);
        end else begin
          due = expected_dates.pop_front();
          dates_checked++;
          if (!due.date.valid_res)
            out_of_range_seen++;
          check_field("valid_res", due.date.valid_res, got.valid_res, due.epoch);
          check_field("year", due.date.year, got.year, due.epoch);
          check_field("month", due.date.month, got.month, due.epoch);
          check_field("day_of_month", due.date.day_of_month, got.day_of_month, due.epoch);
          check_field("hour", due.date.hour, got.hour, due.epoch);
          check_field("minute", due.date.minute, got.minute, due.epoch);
          check_field("second", due.date.second, got.second, due.epoch);
        end
      end
    end
  end

  // Watchdog: drop the run if the block stops moving.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_CAP) begin
      $display("timeout at cycle %0d with %0d dates outstanding", cyc, expected_dates.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    longint     edges[6];
    longint     v;
    logic [63:0] raw;
    int unsigned pick;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;

    // Directed: epoch itself, day edges on both sides of zero, leap days, the
    // era start, a skipped century leap day, both ends of the valid year range
    // and both extremes of the input field.
    pending_epochs.push_back(39'(64'sd0));
    pending_epochs.push_back(39'(-64'sd1));
    pending_epochs.push_back(39'(64'sd1));
    pending_epochs.push_back(39'(64'sd43199));
    pending_epochs.push_back(39'(64'sd86399));
    pending_epochs.push_back(39'(64'sd86400));
    pending_epochs.push_back(39'(-64'sd86400));
    pending_epochs.push_back(39'(-64'sd86401));
    pending_epochs.push_back(39'(64'sd951782400));      // 2000-02-29
    pending_epochs.push_back(39'(64'sd951868799));      // last second of era-year 1999
    pending_epochs.push_back(39'(64'sd951868800));      // 2000-03-01, era start
    pending_epochs.push_back(39'(64'sd1709164800));     // 2024-02-29
    pending_epochs.push_back(39'(-64'sd2203891200));    // 1900-03-01
    pending_epochs.push_back(39'(-64'sd2203891201));    // 1900-02-28 23:59:59
    pending_epochs.push_back(39'(64'sd2147483647));
    pending_epochs.push_back(39'(-64'sd2147483648));
    pending_epochs.push_back(39'(-64'sd62162035200));   // 0000-03-01
    pending_epochs.push_back(39'(-64'sd62167219200));   // 0000-01-01, first valid
    pending_epochs.push_back(39'(-64'sd62167219201));   // year -1, out of range
    pending_epochs.push_back(39'(64'sd253402300799));   // 9999-12-31 23:59:59
    pending_epochs.push_back(39'(64'sd253402300800));   // year 10000, out of range
    pending_epochs.push_back(39'(64'sd274877906943));   // largest input
    pending_epochs.push_back(39'(-64'sd274877906944));  // smallest input
    directed_cnt = pending_epochs.size();

    edges = '{64'sd0, 64'sd951868800, -64'sd62167219200, 64'sd253402300800,
              -64'sd2203891200, -64'sd274877906944};

    // Random: full-width noise, day boundaries across the valid years, windows
    // around the year and era edges, and ordinary 32-bit Unix times.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        raw = {$urandom, $urandom};
        v   = longint'(raw);
      end else if (pick < 65) begin
        v = (longint'($urandom_range(3800000)) - 64'sd800000) * 64'sd86400
            + longint'($urandom_range(4)) - 64'sd2;
      end else if (pick < 80) begin
        v = edges[$urandom_range(5)] + longint'($urandom_range(400000)) - 64'sd200000;
      end else begin
        v = longint'($signed($urandom));
      end
      pending_epochs.push_back(39'(v));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every timestamp is taken and every date has come back; look
    // between edges so the driver's and monitor's updates have settled.
    while (pending_epochs.size() > 0 || in_tvalid)
      @(negedge clk);
    while (expected_dates.size() > 0)
      @(negedge clk);
    // Let the pipeline run dry so stray extra results get caught.
    repeat (DRAIN_CYC) @(posedge clk);

    $display("checked %0d dates (%0d directed timestamps, %0d outside years 0..9999)",
             dates_checked, directed_cnt, out_of_range_seen);
    $display("both sides stalled at random, with a stall-free window; %0d cycles", cyc);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
